### design/isg_pkg.sv
// Package for the interval set: payload structs, codes and sizes.
// Used by interval_set_merge_and_gaps; depends on nothing.
`default_nettype none
package isg_pkg;

  localparam int MaxRanges = 16;
  localparam int LineBits  = 24;
  localparam int IdxBits   = $clog2(MaxRanges);
  localparam int CntBits   = $clog2(MaxRanges + 2);
  localparam int TotBits   = $clog2(MaxRanges + 1);

  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindQuery  = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LineBits-1:0] span_start;
    logic [LineBits-1:0] span_end;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                covered;
    logic                gap_valid;
    logic [LineBits-1:0] gap_start;
    logic [LineBits-1:0] gap_end;
    logic [TotBits-1:0]  range_count;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [LineBits-1:0] lo;
    logic [LineBits-1:0] hi;
  } span_t;

  typedef enum logic [2:0] {
    StIdle,
    StIns,
    StQry,
    StQEnd1,
    StQEnd2
  } state_e;

endpackage
`default_nettype wire

### design/interval_set_merge_and_gaps.sv
// Sorted, coalescing interval set with gap queries over a window.
// Depends on isg_pkg; ranges live in two ping-pong table memories.
//
//  channel | ports                   | handshake
//  --------+-------------------------+-----------------------------------
//  request | req_i, start, busy      | taken when start & !busy
//  result  | res_o, done_o           | each result valid for one cycle, no back pressure
//
// Clear, unused kinds and invalid ranges answer straight from idle. Insert
// and query hold busy while they walk the stored ranges over the read port,
// one entry per cycle; insert pauses on one entry while it writes the merged
// range, and a query stops early when the walk passes the window end.
// Insert copies the merged table into the idle bank and flips banks at the
// end, so a full table is left untouched. Reset empties the table at once.
`default_nettype none
module interval_set_merge_and_gaps (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire isg_pkg::req_t req_i,
  input  wire logic          start,
  output logic               busy,
  output isg_pkg::res_t      res_o,
  output logic               done_o
);

  localparam int LB = isg_pkg::LineBits;
  localparam int IB = isg_pkg::IdxBits;
  localparam int CB = isg_pkg::CntBits;
  localparam int TB = isg_pkg::TotBits;

  isg_pkg::span_t mem_a [isg_pkg::MaxRanges];
  isg_pkg::span_t mem_b [isg_pkg::MaxRanges];
  isg_pkg::span_t rda_q, rdb_q, rd;

  isg_pkg::state_e state_q, state_d;
  logic [TB-1:0] total_q, total_d, i_q, i_d;
  logic [CB-1:0] n_q, n_d;
  logic          bank_q, bank_d, placed_q, placed_d;
  logic [LB-1:0] s_q, e_q, ms_q, ms_d, me_q, me_d;
  logic [LB:0]   cur_q, cur_d;
  logic          pv_q, pv_d;
  logic [LB-1:0] ps_q, ps_d, pe_q, pe_d;
  isg_pkg::res_t res_q, res_d;
  logic          done_q, done_d;

  logic           wr_en;
  logic [CB-1:0]  wr_idx;
  isg_pkg::span_t wr_data;

  logic          accept, walk_end;
  logic [LB:0]   rs_w, re_w, re1, e1, s_w, e_w;
  logic          c_before, c_merge, q_skip, q_past, q_gap, q_stop;
  logic [LB-1:0] gap_hi;
  logic [CB-1:0] fin_cnt;

  assign accept   = start && !busy;
  assign rd       = bank_q ? rdb_q : rda_q;
  assign walk_end = (i_q == total_q);
  assign rs_w     = {1'b0, rd.lo};
  assign re_w     = {1'b0, rd.hi};
  assign re1      = re_w + 1'b1;
  assign s_w      = {1'b0, s_q};
  assign e_w      = {1'b0, e_q};
  assign e1       = e_w + 1'b1;
  assign c_before = re1 < s_w;
  assign c_merge  = rs_w <= e1;
  assign q_skip   = re_w < cur_q;
  assign q_past   = rs_w > e_w;
  assign q_gap    = rs_w > cur_q;
  assign q_stop   = re1 > e_w;
  assign gap_hi   = (rd.lo - 1'b1 < e_q) ? rd.lo - 1'b1 : e_q;
  assign fin_cnt  = placed_q ? n_q : n_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isg_pkg::StIdle: begin
        if (accept && req_i.span_start <= req_i.span_end) begin
          if (req_i.kind == isg_pkg::KindInsert) state_d = isg_pkg::StIns;
          else if (req_i.kind == isg_pkg::KindQuery) state_d = isg_pkg::StQry;
        end
      end
      isg_pkg::StIns: if (walk_end) state_d = isg_pkg::StIdle;
      isg_pkg::StQry: begin
        if (walk_end) state_d = isg_pkg::StQEnd1;
        else if (!q_skip && q_past) state_d = isg_pkg::StQEnd1;
        else if (!q_skip && q_stop) state_d = isg_pkg::StQEnd2;
      end
      isg_pkg::StQEnd1: state_d = isg_pkg::StQEnd2;
      isg_pkg::StQEnd2: state_d = isg_pkg::StIdle;
      default:          state_d = isg_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    total_d  = total_q;
    bank_d   = bank_q;
    i_d      = i_q;
    n_d      = n_q;
    placed_d = placed_q;
    ms_d     = ms_q;
    me_d     = me_q;
    cur_d    = cur_q;
    pv_d     = pv_q;
    ps_d     = ps_q;
    pe_d     = pe_q;
    res_d    = '0;
    done_d   = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = n_q;
    wr_data  = rd;
    res_d.range_count = total_q;
    res_d.last        = 1'b1;
    unique case (state_q)
      isg_pkg::StIdle: begin
        i_d      = '0;
        n_d      = '0;
        placed_d = 1'b0;
        ms_d     = req_i.span_start;
        me_d     = req_i.span_end;
        cur_d    = {1'b0, req_i.span_start};
        pv_d     = 1'b0;
        if (accept) begin
          if (req_i.kind == isg_pkg::KindClear) begin
            total_d           = '0;
            res_d.range_count = '0;
            done_d            = 1'b1;
          end else if (req_i.kind != isg_pkg::KindInsert &&
                       req_i.kind != isg_pkg::KindQuery) begin
            done_d = 1'b1;
          end else if (req_i.span_start > req_i.span_end) begin
            res_d.status = isg_pkg::StatusInvalid;
            done_d       = 1'b1;
          end
        end
      end
      isg_pkg::StIns: begin
        if (walk_end) begin
          // place the merged range if nothing came after it, then commit unless the table would overflow
          if (!placed_q) begin
            wr_en   = 1'b1;
            wr_data = '{lo: ms_q, hi: me_q};
          end
          done_d = 1'b1;
          if (fin_cnt > CB'(isg_pkg::MaxRanges)) begin
            res_d.status = isg_pkg::StatusFull;
          end else begin
            total_d           = TB'(fin_cnt);
            bank_d            = !bank_q;
            res_d.range_count = TB'(fin_cnt);
          end
        end else if (c_before) begin
          wr_en = 1'b1;
          n_d   = n_q + 1'b1;
          i_d   = i_q + 1'b1;
        end else if (c_merge) begin
          if (rd.lo < ms_q) ms_d = rd.lo;
          if (rd.hi > me_q) me_d = rd.hi;
          i_d = i_q + 1'b1;
        end else if (!placed_q) begin
          // hold the current entry while the merged range is written
          wr_en    = 1'b1;
          wr_data  = '{lo: ms_q, hi: me_q};
          n_d      = n_q + 1'b1;
          placed_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          n_d   = n_q + 1'b1;
          i_d   = i_q + 1'b1;
        end
      end
      isg_pkg::StQry: begin
        if (!walk_end) begin
          if (q_skip) begin
            i_d = i_q + 1'b1;
          end else if (!q_past) begin
            if (q_gap) begin
              res_d.gap_valid = 1'b1;
              res_d.gap_start = ps_q;
              res_d.gap_end   = pe_q;
              res_d.last      = 1'b0;
              done_d          = pv_q;
              pv_d            = 1'b1;
              ps_d            = cur_q[LB-1:0];
              pe_d            = gap_hi;
            end
            cur_d = re1;
            i_d   = i_q + 1'b1;
          end
        end
      end
      isg_pkg::StQEnd1: begin
        if (cur_q <= e_w) begin
          res_d.gap_valid = 1'b1;
          res_d.gap_start = ps_q;
          res_d.gap_end   = pe_q;
          res_d.last      = 1'b0;
          done_d          = pv_q;
          pv_d            = 1'b1;
          ps_d            = cur_q[LB-1:0];
          pe_d            = e_q;
        end
      end
      isg_pkg::StQEnd2: begin
        done_d = 1'b1;
        if (pv_q) begin
          res_d.gap_valid = 1'b1;
          res_d.gap_start = ps_q;
          res_d.gap_end   = pe_q;
        end else begin
          res_d.covered = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // table banks: read the active bank, write the idle one
  always_ff @(posedge clk_i) begin
    if (wr_en && n_q < CB'(isg_pkg::MaxRanges)) begin
      if (bank_q) mem_a[wr_idx[IB-1:0]] <= wr_data;
      else        mem_b[wr_idx[IB-1:0]] <= wr_data;
    end
    rda_q <= mem_a[i_d[IB-1:0]];
    rdb_q <= mem_b[i_d[IB-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= isg_pkg::StIdle;
      total_q  <= '0;
      bank_q   <= 1'b0;
      i_q      <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      pv_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      bank_q   <= bank_d;
      i_q      <= i_d;
      n_q      <= n_d;
      placed_q <= placed_d;
      pv_q     <= pv_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= req_i.span_start;
      e_q <= req_i.span_end;
    end
    ms_q  <= ms_d;
    me_q  <= me_d;
    cur_q <= cur_d;
    ps_q  <= ps_d;
    pe_q  <= pe_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != isg_pkg::StIdle);
  assign res_o  = res_q;
  assign done_o = done_q;

endmodule
`default_nettype wire
